// File: rtl/npp_pkg.sv
// Package with the shared constants, types and codes of the nearest pending point picker.
package npp_pkg;

  localparam int POINT_SLOTS = 32;
  localparam int SLOT_W      = (POINT_SLOTS > 1) ? $clog2(POINT_SLOTS) : 1;
  localparam int CNT_W       = $clog2(POINT_SLOTS + 1);
  localparam int COORD_W     = 7;
  localparam int GOAL_Y_W    = 8;
  localparam int IDX_W       = 5;
  localparam int COUNT_W     = 6;
  localparam int SQ_W        = 14;
  localparam int DIST_W      = 16;

  localparam logic [DIST_W-1:0]   DIST_LIMIT = 16'd50000;
  localparam logic [GOAL_Y_W-1:0] Y_OFFSET   = 8'd1;

  typedef enum logic [2:0] {
    OUT_PICKED = 3'd0,
    OUT_HOME   = 3'd1,
    OUT_NONE   = 3'd2,
    OUT_LOADED = 3'd3,
    OUT_ABOVE  = 3'd4
  } npp_outcome_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_PICK = 1'b1
  } npp_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } npp_state_t;

  typedef struct packed {
    logic                       done;
    logic                       hit;
    logic [SLOT_W-1:0]          idx;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
  } npp_scan_res_t;

endpackage

// File: rtl/npp_point_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module npp_point_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 14
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(DEPTH)-1:0]        waddr,
  input  logic [WIDTH-1:0]                wdata,
  input  logic                            re,
  input  logic [$clog2(DEPTH)-1:0]        raddr,
  output logic [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/npp_scan.sv
// Pipelined scan over the point store that finds the nearest pending point.
module npp_scan
  import npp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [COORD_W-1:0]  car_x,
  input  logic signed [COORD_W-1:0]  car_y,
  output logic                       rd_en,
  output logic [SLOT_W-1:0]          rd_addr,
  input  logic signed [COORD_W-1:0]  rd_x,
  input  logic signed [COORD_W-1:0]  rd_y,
  input  logic                       rd_pend,
  output npp_scan_res_t              res
);

  logic                      busy;
  logic [CNT_W-1:0]          cnt;
  logic                      issue_last;
  logic signed [COORD_W-1:0] cx;
  logic signed [COORD_W-1:0] cy;

  logic                      v1;
  logic                      last1;
  logic [SLOT_W-1:0]         idx1;

  logic                      v2;
  logic                      last2;
  logic                      pend2;
  logic [SLOT_W-1:0]         idx2;
  logic signed [COORD_W-1:0] x2;
  logic signed [COORD_W-1:0] y2;
  logic signed [7:0]         dx2;
  logic signed [7:0]         dy2;

  logic                      v3;
  logic                      last3;
  logic                      pend3;
  logic [SLOT_W-1:0]         idx3;
  logic signed [COORD_W-1:0] x3;
  logic signed [COORD_W-1:0] y3;
  logic [SQ_W-1:0]           sqx3;
  logic [SQ_W-1:0]           sqy3;

  logic signed [15:0]        prod_x;
  logic signed [15:0]        prod_y;
  logic [DIST_W-1:0]         sq_dist;
  logic [DIST_W-1:0]         best;
  logic                      better;

  assign rd_en      = busy;
  assign rd_addr    = cnt[SLOT_W-1:0];
  assign issue_last = (cnt == CNT_W'(POINT_SLOTS - 1));

  assign prod_x  = dx2 * dx2;
  assign prod_y  = dy2 * dy2;
  assign sq_dist = DIST_W'(sqx3) + DIST_W'(sqy3);
  assign better  = v3 && pend3 && (sq_dist < best);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      res.done <= 1'b0;
    end else begin
      res.done <= v3 && last3;
      v1       <= busy;
      v2       <= v1;
      v3       <= v2;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (issue_last) begin
          busy <= 1'b0;
        end
      end
      if (start) begin
        res.hit <= 1'b0;
        res.idx <= '0;
        res.x   <= '0;
        res.y   <= '0;
      end else if (better) begin
        res.hit <= 1'b1;
        res.idx <= idx3;
        res.x   <= x3;
        res.y   <= y3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cx   <= car_x;
      cy   <= car_y;
      best <= DIST_LIMIT;
    end else if (better) begin
      best <= sq_dist;
    end
    last1 <= issue_last;
    idx1  <= rd_addr;
    last2 <= last1;
    idx2  <= idx1;
    pend2 <= rd_pend;
    x2    <= rd_x;
    y2    <= rd_y;
    dx2   <= 8'(rd_x) - 8'(cx);
    dy2   <= 8'(rd_y) - 8'(cy);
    last3 <= last2;
    idx3  <= idx2;
    pend3 <= pend2;
    x3    <= x2;
    y3    <= y2;
    sqx3  <= prod_x[SQ_W-1:0];
    sqy3  <= prod_y[SQ_W-1:0];
  end

endmodule

// File: rtl/nearest_pending_point_picker_core.sv
// Top level of the nearest pending point picker: command control, marks and result register.
// A load writes its entry and then emits its result; a pick that scans steps through
// the point store one entry per cycle and feeds each entry through the three-stage
// distance pipeline; other picks emit their result without a scan.
// One command is worked on at a time, so a new transfer is taken only in the idle state.
// Reset clears the pending marks, the target count and all control state; the point
// store is not cleared and needs no pass.
module nearest_pending_point_picker_core
  import npp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // entry_index, entry_x, entry_y, entry_pending, car_x, car_y, found_count
  input  logic [39:0]         s_axis_tdata,
  // command
  input  logic [0:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // goal_x, goal_y, chosen_index, zero padding
  output logic [23:0]         m_axis_tdata,
  // outcome
  output logic [2:0]          m_axis_tuser,
  input  logic                cfg_wen,
  input  logic [COUNT_W-1:0]  cfg_wdata
);

  npp_state_t state;
  npp_state_t state_next;

  logic [COUNT_W-1:0]         target_count;
  logic [POINT_SLOTS-1:0]     marks;

  logic [IDX_W-1:0]           entry_index;
  logic signed [COORD_W-1:0]  entry_x;
  logic signed [COORD_W-1:0]  entry_y;
  logic                       entry_pending;
  logic signed [COORD_W-1:0]  car_x;
  logic signed [COORD_W-1:0]  car_y;
  logic [COUNT_W-1:0]         found_count;
  npp_cmd_t                   command;

  logic                       accept;
  logic                       load_we;
  logic                       scan_start;
  logic                       out_load;
  logic                       load_in_range;

  logic                       rd_en;
  logic [SLOT_W-1:0]          rd_addr;
  logic [2*COORD_W-1:0]       rd_data;
  logic                       rd_pend;
  npp_scan_res_t              scan_res;

  logic signed [COORD_W-1:0]  res_x;
  logic signed [GOAL_Y_W-1:0] res_y;
  logic [IDX_W-1:0]           res_idx;
  npp_outcome_t               res_outcome;

  logic signed [COORD_W-1:0]  out_x;
  logic signed [GOAL_Y_W-1:0] out_y;
  logic [IDX_W-1:0]           out_idx;
  npp_outcome_t               out_outcome;
  logic                       out_valid;

  assign entry_index   = s_axis_tdata[4:0];
  assign entry_x       = s_axis_tdata[11:5];
  assign entry_y       = s_axis_tdata[18:12];
  assign entry_pending = s_axis_tdata[19];
  assign car_x         = s_axis_tdata[26:20];
  assign car_y         = s_axis_tdata[33:27];
  assign found_count   = s_axis_tdata[39:34];
  assign command       = npp_cmd_t'(s_axis_tuser[0]);

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load_in_range = (32'(entry_index) < POINT_SLOTS);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_idx, out_y, out_x};
  assign m_axis_tuser  = out_outcome;

  npp_point_ram #(
    .DEPTH (POINT_SLOTS),
    .WIDTH (2 * COORD_W)
  ) u_point_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (SLOT_W'(entry_index)),
    .wdata ({entry_y, entry_x}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  npp_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (scan_start),
    .car_x   (car_x),
    .car_y   (car_y),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_x    (rd_data[COORD_W-1:0]),
    .rd_y    (rd_data[2*COORD_W-1:COORD_W]),
    .rd_pend (rd_pend),
    .res     (scan_res)
  );

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    load_we       = 1'b0;
    scan_start    = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (command == CMD_LOAD) begin
            load_we    = load_in_range;
            state_next = ST_EMIT;
          end else if (found_count < target_count) begin
            scan_start = 1'b1;
            state_next = ST_SCAN;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_count <= '0;
    end else if (cfg_wen) begin
      target_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      marks <= '0;
    end else if (load_we) begin
      marks[SLOT_W'(entry_index)] <= entry_pending;
    end else if (state == ST_SCAN && scan_res.done && scan_res.hit) begin
      marks[scan_res.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_pend <= marks[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_x   <= '0;
      res_y   <= '0;
      res_idx <= '0;
      if (command == CMD_LOAD) begin
        res_outcome <= OUT_LOADED;
      end else if (found_count == target_count) begin
        res_outcome <= OUT_HOME;
      end else begin
        res_outcome <= OUT_ABOVE;
      end
    end else if (state == ST_SCAN && scan_res.done) begin
      if (scan_res.hit) begin
        res_x       <= scan_res.x;
        res_y       <= GOAL_Y_W'(scan_res.y) - Y_OFFSET;
        res_idx     <= IDX_W'(scan_res.idx);
        res_outcome <= OUT_PICKED;
      end else begin
        res_x       <= '0;
        res_y       <= '0;
        res_idx     <= '0;
        res_outcome <= OUT_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x       <= res_x;
      out_y       <= res_y;
      out_idx     <= res_idx;
      out_outcome <= res_outcome;
    end
  end

endmodule
